/* sv/te3_pkg.sv */
// Shared types and constants for the threshold erosion 3x3 core.
// No dependencies; imported by te3_line_cell, threshold_erosion_3x3_core and the bench.
package te3_pkg;

  localparam int SAMPLE_W = 13;
  localparam int THR_W    = 12;
  localparam int SIZE_W   = 11;
  localparam int COORD_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 12'd320;
  localparam logic [SIZE_W-1:0] FRAME_COLS_RST = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_ROWS_RST = 11'd480;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } line_ctl_t;

endpackage

/* sv/te3_line_cell.sv */
// One cell of the flag chain: a one-bit line store with read bypass and a
// two-column window over the bit it is handed. Depends on te3_pkg.
module te3_line_cell #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  te3_pkg::line_ctl_t   ctl_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic                 wr_data_i,
  output logic                 rd_data_o,
  output logic [1:0]           win_o
);
  import te3_pkg::*;

  logic             mem_q [Depth];
  logic             rd_q;
  logic             byp_q;
  logic             byp_data_q;
  logic [1:0]       win_q;
  logic [1:0]       win_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // same-address write on the read edge: take the new bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
      win_q <= '0;
    end else begin
      if (ctl_i.rd_en) begin
        byp_q <= ctl_i.wr_en && (rd_addr_i == wr_addr_i);
      end
      win_q <= win_d;
    end
  end

  always_comb begin
    win_d = win_q;
    if (ctl_i.wr_en) begin
      win_d = {win_q[0], wr_data_i};
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;
  assign win_o     = win_q;

endmodule

/* sv/threshold_erosion_3x3_core.sv */
// Threshold erosion 3x3 top level: flag compare, position counters, chain of
// two line cells, erosion AND and output register. Depends on te3_pkg, te3_line_cell.
//
// Takes one sample per clock as long as results are taken. A result held on the
// output stalls the input once the next request that emits reaches the second
// stage. The compare and line-store read are registered into that stage, the
// window AND and line-store write follow from it, and a result register parts
// the output. A result passes both registers and describes the pixel clamped
// frame_cols+1 raster positions behind it. The last row and the last pixel of
// the row above it are never sent and read as off. Each line store has one
// write and one read port per cycle; a read of the address being written that
// cycle is bypassed.
module threshold_erosion_3x3_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [te3_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [te3_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [te3_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,  // [12:0] sample
  input  logic                               s_axis_tuser_i,  // [0] frame_start
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [te3_pkg::M_TDATA_W-1:0]      m_axis_tdata_o   // [0] pixel_on,
                                                              // [10:1] out_row,
                                                              // [20:11] out_col
);
  import te3_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CW1 = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RW1 = $clog2(MAX_ROWS + 1);

  logic [THR_W-1:0]  threshold_q;
  logic [SIZE_W-1:0] frame_cols_q;
  logic [SIZE_W-1:0] frame_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      frame_cols_q <= FRAME_COLS_RST;
      frame_rows_q <= FRAME_ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:  threshold_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_FRAME_COLS: frame_cols_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_FRAME_ROWS: frame_rows_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0]    fc32, fr32, cols32, rows32;
  logic [CW1-1:0] cols;
  logic [RW1-1:0] rows;

  always_comb begin
    fc32   = 32'(frame_cols_q);
    fr32   = 32'(frame_rows_q);
    cols32 = (fc32 < 32'd3) ? 32'd3 : ((fc32 > 32'(MAX_COLS)) ? 32'(MAX_COLS) : fc32);
    rows32 = (fr32 < 32'd3) ? 32'd3 : ((fr32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : fr32);
    cols   = cols32[CW1-1:0];
    rows   = rows32[RW1-1:0];
  end

  // handshake
  logic s_acc, st1_v_q, st1_adv, st1_emit, m_valid_q, out_free;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign st1_adv         = st1_v_q && (out_free || !st1_emit);
  assign s_axis_tready_o = !st1_v_q || st1_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // flag
  logic signed [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W:0]          mag;
  logic                       flag;

  always_comb begin
    sample = signed'(s_axis_tdata_i[SAMPLE_W-1:0]);
    mag    = sample[SAMPLE_W-1] ? (14'd0 - 14'(sample)) : 14'(sample);
    flag   = mag > (SAMPLE_W+1)'(threshold_q);
  end

  // raster position
  logic [CW-1:0]  col_q, col_d, c_cur;
  logic [RW-1:0]  row_q, row_d, r_cur;
  logic [CW1-1:0] c0, cn;
  logic [RW1-1:0] r0, rn;

  always_comb begin
    c0 = s_axis_tuser_i ? '0 : CW1'(col_q);
    r0 = s_axis_tuser_i ? '0 : RW1'(row_q);
    if (c0 >= cols) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= rows) begin
      r0 = '0;
    end
    c_cur = c0[CW-1:0];
    r_cur = r0[RW-1:0];
    cn    = c0 + 1'b1;
    rn    = r0;
    if (cn >= cols) begin
      cn = '0;
      rn = r0 + 1'b1;
      if (rn >= rows) begin
        rn = '0;
      end
    end
    col_d = s_acc ? cn[CW-1:0] : col_q;
    row_d = s_acc ? rn[RW-1:0] : row_q;
  end

  logic          st1_flag_q;
  logic [CW-1:0] st1_c_q;
  logic [RW-1:0] st1_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      st1_v_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      st1_v_q <= s_acc || (st1_v_q && !st1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      st1_flag_q <= flag;
      st1_c_q    <= c_cur;
      st1_r_q    <= r_cur;
    end
  end

  // chain of line cells: flags of row r feed the newer line, its output the older
  line_ctl_t ctl;
  logic       up1, up2;
  logic [1:0] win0, win1, win2_q;

  assign ctl.rd_en = s_acc;
  assign ctl.wr_en = st1_adv;

  te3_line_cell #(.Depth(MAX_COLS), .AddrW(CW)) u_newer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_i (c_cur),
    .wr_addr_i (st1_c_q),
    .wr_data_i (st1_flag_q),
    .rd_data_o (up1),
    .win_o     (win0)
  );

  te3_line_cell #(.Depth(MAX_COLS), .AddrW(CW)) u_older (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_i (c_cur),
    .wr_addr_i (st1_c_q),
    .wr_data_i (up1),
    .rd_data_o (up2),
    .win_o     (win1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win2_q <= '0;
    end else if (st1_adv) begin
      win2_q <= {win2_q[0], up2};
    end
  end

  // erosion and result
  logic               c_nz, r_ge1, r_ge2, c_ge2, pix_on;
  logic [31:0]        row32, col32;
  logic [M_TDATA_W-1:0] m_data_q;

  always_comb begin
    c_nz     = st1_c_q != '0;
    c_ge2    = 32'(st1_c_q) >= 32'd2;
    r_ge1    = st1_r_q != '0;
    r_ge2    = 32'(st1_r_q) >= 32'd2;
    st1_emit = c_nz ? r_ge1 : r_ge2;
    pix_on   = r_ge2 && c_ge2 && st1_flag_q && up1 && up2 &&
               (win0 == 2'b11) && (win1 == 2'b11) && (win2_q == 2'b11);
    row32    = 32'(st1_r_q) - (c_nz ? 32'd1 : 32'd2);
    col32    = c_nz ? (32'(st1_c_q) - 32'd1) : (32'(cols) - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (st1_adv && st1_emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st1_adv && st1_emit) begin
      m_data_q <= {3'b000, col32[COORD_W-1:0], row32[COORD_W-1:0], pix_on};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> st1_v_q && m_valid_q && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st1_adv && st1_emit) |=> m_axis_tvalid_o)
    else $error("emitted result not presented");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st1_v_q && st1_emit && !out_free) |=> st1_v_q && $stable(st1_c_q) && $stable(st1_r_q))
    else $error("pending item lost while output blocked");
`endif

endmodule

/* bench/threshold_erosion_3x3_checker.sv */
// Scoreboard for threshold_erosion_3x3_core: follows config writes and accepted
// pixel requests, predicts each eroded pixel and compares the output stream.
// Depends on te3_pkg.
module threshold_erosion_3x3_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [te3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [te3_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [te3_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // [12:0] sample
  input  logic                           s_axis_tuser_i,  // [0] frame_start
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [te3_pkg::M_TDATA_W-1:0]  m_axis_tdata_i,  // [0] pixel_on, [10:1] out_row,
                                                          // [20:11] out_col
  output int                             mismatch_cnt_o,
  output int                             pending_cnt_o
);
  import te3_pkg::*;

  localparam int LINE_DEPTH = 1024;

  typedef struct packed {
    logic               on;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } eroded_px_t;

  bit               older_flags [LINE_DEPTH];
  bit               newer_flags [LINE_DEPTH];
  logic [5:0]       win_flags;
  int               col_pos;
  int               row_pos;
  logic [THR_W-1:0] thr_q;
  logic [SIZE_W-1:0] cols_q;
  logic [SIZE_W-1:0] rows_q;
  eroded_px_t       eroded_q [$];

  bit               emit;
  eroded_px_t       px_new;
  eroded_px_t       px_exp;

  function automatic int clamp_size(logic [SIZE_W-1:0] v);
    if (v < 3) return 3;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return int'(v);
  endfunction

  task automatic erode_pixel(input logic [SAMPLE_W-1:0] smp, input logic fs,
                             output bit has_px, output eroded_px_t px);
    int         cols;
    int         rows;
    int         mag;
    logic       flag;
    logic [2:0] col3;
    cols = clamp_size(cols_q);
    rows = clamp_size(rows_q);
    mag  = smp[SAMPLE_W-1] ? (8192 - int'(smp)) : int'(smp);
    flag = (mag > int'(thr_q));
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    col3   = {flag, newer_flags[col_pos], older_flags[col_pos]};
    has_px = 1'b0;
    px     = '0;
    if (col_pos >= 1) begin
      if (row_pos >= 1) begin
        px.on  = (row_pos >= 2) && (col_pos >= 2) && (col3 == 3'b111) &&
                 (win_flags == 6'h3f);
        px.row = COORD_W'(row_pos - 1);
        px.col = COORD_W'(col_pos - 1);
        has_px = 1'b1;
      end
    end else if (row_pos >= 2) begin
      px.row = COORD_W'(row_pos - 2);
      px.col = COORD_W'(cols - 1);
      has_px = 1'b1;
    end
    older_flags[col_pos] = col3[1];
    newer_flags[col_pos] = flag;
    win_flags = {win_flags[2:0], col3};
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        older_flags[i] = 1'b0;
        newer_flags[i] = 1'b0;
      end
      win_flags      = '0;
      col_pos        = 0;
      row_pos        = 0;
      thr_q          = THRESHOLD_RST;
      cols_q         = FRAME_COLS_RST;
      rows_q         = FRAME_ROWS_RST;
      eroded_q.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD:  thr_q  = cfg_wdata_i[THR_W-1:0];
          CFG_FRAME_COLS: cols_q = cfg_wdata_i[SIZE_W-1:0];
          CFG_FRAME_ROWS: rows_q = cfg_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        erode_pixel(s_axis_tdata_i[SAMPLE_W-1:0], s_axis_tuser_i, emit, px_new);
        if (emit) eroded_q.push_back(px_new);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (eroded_q.size() == 0) begin
          $error("unexpected result: tdata %h", m_axis_tdata_i);
          mismatch_cnt_o++;
        end else begin
          px_exp = eroded_q.pop_front();
          if (m_axis_tdata_i[0] !== px_exp.on) begin
            $error("pixel_on: expected %0d, actual %0d", px_exp.on, m_axis_tdata_i[0]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata_i[10:1] !== px_exp.row) begin
            $error("out_row: expected %0d, actual %0d", px_exp.row, m_axis_tdata_i[10:1]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata_i[20:11] !== px_exp.col) begin
            $error("out_col: expected %0d, actual %0d", px_exp.col, m_axis_tdata_i[20:11]);
            mismatch_cnt_o++;
          end
        end
      end
      pending_cnt_o = eroded_q.size();
    end
  end

endmodule

/* bench/threshold_erosion_3x3_core_tb.sv */
// Top of the threshold erosion 3x3 bench: clock, reset, config writes, pixel
// stimulus with random gaps and output back-pressure, and the final verdict.
// Depends on te3_pkg, threshold_erosion_3x3_core, threshold_erosion_3x3_checker.
module threshold_erosion_3x3_core_tb;
  import te3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int N_DIRECTED   = 25;

  // frame A all flags set, frame B with a cleared center, then a run across frame end
  localparam logic [SAMPLE_W-1:0] DIRECTED_SAMPLES [N_DIRECTED] = '{
    13'h1000, 13'h0FFF, 13'h1010, 13'h0FF0, 13'h0001, 13'h1FFF, 13'h0010, 13'h1FF0,
    13'h0800,
    13'h0AAA, 13'h1555, 13'h0001, 13'h1FFF, 13'h0000, 13'h0FFF, 13'h1000, 13'h0123,
    13'h1ABC,
    13'h0FFF, 13'h1000, 13'h0010, 13'h1FF0, 13'h0555, 13'h1AAA, 13'h0002
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  pix_valid = 1'b0;
  logic [S_TDATA_W-1:0]  pix_data  = '0;
  logic                  pix_start = 1'b0;
  logic                  res_ready = 1'b0;
  logic                  pix_ready;
  logic                  res_valid;
  logic [M_TDATA_W-1:0]  res_data;

  int mismatch_cnt;
  int pending_cnt;
  int cycle_cnt     = 0;
  int pixels_sent   = 0;
  int cur_cols      = 640;
  bit pressure_done = 1'b0;
  int hold_cnt      = 0;
  int run_cnt       = 0;

  always #5 clk_i = ~clk_i;

  threshold_erosion_3x3_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_o (pix_ready),
    .s_axis_tdata_i  (pix_data),
    .s_axis_tuser_i  (pix_start),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  threshold_erosion_3x3_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_i (pix_ready),
    .s_axis_tdata_i  (pix_data),
    .s_axis_tuser_i  (pix_start),
    .m_axis_tvalid_i (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_i  (res_data),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // raw sample, or magnitude drawn above or below the threshold, with hits on the boundary
  function automatic logic [SAMPLE_W-1:0] pick_sample(int thr, int bias);
    int r;
    int mag;
    bit neg;
    r   = $urandom_range(0, 99);
    neg = $urandom_range(0, 1);
    if (r < 8) return SAMPLE_W'($urandom_range(0, 8191));
    if (r < 16) mag = thr + $urandom_range(0, 1);
    else if ($urandom_range(1, 100) <= bias) mag = $urandom_range(thr + 1, 4096);
    else mag = $urandom_range(0, thr);
    if (mag >= 4096) begin
      mag = 4096;
      neg = 1'b1;
    end
    return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pixel(input logic [SAMPLE_W-1:0] smp, input logic fs, input bit gappy);
    int gap;
    gap = gappy ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_valid <= 1'b1;
    pix_data  <= S_TDATA_W'(smp);
    pix_start <= fs;
    do @(posedge clk_i); while (!pix_ready);
    pixels_sent++;
  endtask

  task automatic wait_drained(input int settle);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic run_phase(input int thr, input int cols, input int rows, input int n,
                           input int bias, input bit gappy, input bit fs_first);
    int eff;
    wait_drained(8);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_FRAME_COLS, cols);
    write_reg(CFG_FRAME_ROWS, rows);
    eff = (cols < 3) ? 3 : (cols > 1024) ? 1024 : cols;
    // wider rows reach line store entries that were never filled
    if (eff > cur_cols) fs_first = 1'b1;
    cur_cols = eff;
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_sample(thr, bias),
                 (i == 0 && fs_first) || ($urandom_range(0, 119) == 0), gappy);
    end
    @(negedge clk_i);
    pix_valid <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (!pressure_done && pixels_sent >= 80) begin
      pressure_done = 1'b1;
      hold_cnt      = 300;
      run_cnt       = 0;
    end
    if (hold_cnt == 0 && run_cnt == 0) begin
      hold_cnt = pick_gap();
      run_cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    if (hold_cnt > 0) begin
      res_ready <= 1'b0;
      hold_cnt--;
    end else begin
      res_ready <= 1'b1;
      run_cnt--;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_no;
    int thr;
    int cols;
    int rows;
    int n;
    int bias;
    bit gappy;
    bit fs_first;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_FRAME_COLS, 3);
    write_reg(CFG_FRAME_ROWS, 3);
    write_reg(CFG_UNUSED, $urandom_range(0, 4095));
    cur_cols = 3;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(DIRECTED_SAMPLES[i], (i == 0) || (i == 9), 1'b1);
    end
    @(negedge clk_i);
    pix_valid <= 1'b0;

    phase_no = 0;
    while (pixels_sent < N_DIRECTED + RANDOM_ITEMS) begin
      phase_no++;
      fs_first = $urandom_range(0, 1);
      gappy    = ($urandom_range(0, 3) != 0);
      n        = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0:       bias = 50;
        1:       bias = 85;
        2:       bias = 95;
        default: bias = 100;
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 4080;
        2:       thr = 320;
        3:       thr = 4095;
        default: thr = $urandom_range(0, 4095);
      endcase
      cols = ($urandom_range(0, 99) < 85) ? $urandom_range(3, 12) : $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0:       rows = $urandom_range(0, 2);
        1:       rows = 2047;
        default: rows = $urandom_range(3, 8);
      endcase
      if (phase_no == 1) begin
        thr   = 4095;
        cols  = 0;
        rows  = 1;
        n     = 150;
        bias  = 95;
        gappy = 1'b0;
      end else if (phase_no == 3) begin
        thr  = 4080;
        cols = 2047;
        rows = 2047;
        n    = 1060;
        bias = 95;
      end else if (phase_no == 4) begin
        // shrink from the widest row while in the middle of a frame
        cols     = 5;
        rows     = 4;
        fs_first = 1'b0;
      end
      run_phase(thr, cols, rows, n, bias, gappy, fs_first);
    end

    wait_drained(20);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
